@@ rtl/core/rle8_pkg.sv @@
// ----------------------------------------------------------------------------
// RLE8 bitmap decoder package
// Shared constants, result codes, decoder phases and the result record.
// ----------------------------------------------------------------------------
package rle8_pkg;

	// Frame limits; register values above these act as the limit
	localparam int MAX_WIDTH  = 4096;
	localparam int MAX_HEIGHT = 4096;

	// Field widths
	localparam int DIM_W   = 13;           // frame size registers, column
	localparam int LINE_W  = DIM_W + 1;    // signed row, reaches -1
	localparam int POS_W   = 12;           // col/row fields of a result
	localparam int BYTE_W  = 8;
	localparam int REG_W   = 2;            // configuration register index

	localparam logic [DIM_W-1:0] MAX_WIDTH_C  = DIM_W'(MAX_WIDTH);
	localparam logic [DIM_W-1:0] MAX_HEIGHT_C = DIM_W'(MAX_HEIGHT);

	// Configuration register indexes
	localparam logic [REG_W-1:0] REG_FRAME_WIDTH  = 2'd0;
	localparam logic [REG_W-1:0] REG_FRAME_HEIGHT = 2'd1;

	// Result kinds
	typedef enum logic [1:0] {
		KIND_RUN   = 2'd0,
		KIND_PIXEL = 2'd1,
		KIND_DONE  = 2'd2,
		KIND_ERROR = 2'd3
	} kind_t;

	// Decoder phases, one-hot
	typedef enum logic [7:0] {
		PH_START   = 8'b0000_0001,
		PH_COUNT   = 8'b0000_0010,
		PH_VALUE   = 8'b0000_0100,
		PH_DX      = 8'b0000_1000,
		PH_DY      = 8'b0001_0000,
		PH_LITERAL = 8'b0010_0000,
		PH_PAD     = 8'b0100_0000,
		PH_DISCARD = 8'b1000_0000
	} phase_t;

	// One result item
	typedef struct packed {
		kind_t              kind;
		logic [POS_W-1:0]   col;
		logic [POS_W-1:0]   row;
		logic [BYTE_W-1:0]  run_length;
		logic [BYTE_W-1:0]  pixel_index;
		logic [DIM_W-1:0]   dirty_first_row;
		logic [DIM_W-1:0]   dirty_end_row;
		logic               last;
	} result_t;

	// Results produced by one byte: zero, one or two, first in res0
	typedef struct packed {
		logic [1:0] cnt;
		result_t    res0;
		result_t    res1;
	} push_t;

endpackage

@@ rtl/core/rle8_ifs.sv @@
// ----------------------------------------------------------------------------
// RLE8 bitmap decoder channels
// Valid/ready interfaces for the byte input, result output and register port.
// ----------------------------------------------------------------------------
interface rle8_in_if;
	logic       valid;
	logic       ready;
	logic [7:0] data_byte;
	logic       last_byte;

	modport source (output valid, output data_byte, output last_byte, input ready);
	modport sink   (input valid, input data_byte, input last_byte, output ready);
endinterface

interface rle8_out_if;
	logic        valid;
	logic        ready;
	logic [1:0]  kind;
	logic [11:0] col;
	logic [11:0] row;
	logic [7:0]  run_length;
	logic [7:0]  pixel_index;
	logic [12:0] dirty_first_row;
	logic [12:0] dirty_end_row;
	logic        last;

	modport source (output valid, output kind, output col, output row,
		output run_length, output pixel_index, output dirty_first_row,
		output dirty_end_row, output last, input ready);
	modport sink   (input valid, input kind, input col, input row,
		input run_length, input pixel_index, input dirty_first_row,
		input dirty_end_row, input last, output ready);
endinterface

interface rle8_cfg_if;
	logic        valid;
	logic        ready;
	logic [1:0]  reg_index;
	logic [12:0] write_data;

	modport source (output valid, output reg_index, output write_data, input ready);
	modport sink   (input valid, input reg_index, input write_data, output ready);
endinterface

@@ rtl/core/rle8_dec_core.sv @@
// ----------------------------------------------------------------------------
// RLE8 decode core
// Packet state and one-byte decode; produces up to two results per byte.
// ----------------------------------------------------------------------------
module rle8_dec_core
	import rle8_pkg::*;
(
	input  logic              clk,
	input  logic              arst_n,
	input  logic              fire,
	input  logic [BYTE_W-1:0] data_byte,
	input  logic              last_byte,
	input  logic [DIM_W-1:0]  frame_width,
	input  logic [DIM_W-1:0]  frame_height,
	output push_t             push
);

	phase_t             phase_q, c_ph, n_ph;
	logic [DIM_W-1:0]   column_q, c_col, n_col;
	logic [LINE_W-1:0]  line_q, c_line, n_line;
	logic [DIM_W-1:0]   dlo_q, c_dlo, n_dlo;
	logic [DIM_W-1:0]   dhi_q, c_dhi, n_dhi;
	logic [BYTE_W-1:0]  count_q, n_count;
	logic [BYTE_W-1:0]  lit_q, n_lit, lit_dec;
	logic               pad_q, n_pad;
	logic [BYTE_W-1:0]  dx_q, n_dx;

	logic [DIM_W-1:0]   w_eff, h_eff;
	logic [LINE_W-1:0]  sum_count, sum_byte, sum_dx;
	logic               bad_count, bad_byte, bad_dx, bad_dy, line_neg;
	logic [DIM_W-1:0]   mark_lo, mark_hi;
	logic               paint, finish, err;
	result_t            paint_res, end_res;

	// Clamp the frame size to the supported limits
	assign w_eff = (frame_width  > MAX_WIDTH_C)  ? MAX_WIDTH_C  : frame_width;
	assign h_eff = (frame_height > MAX_HEIGHT_C) ? MAX_HEIGHT_C : frame_height;

	// Reload position and dirty span at the first byte of a packet
	always_comb begin
		if (phase_q == PH_START) begin
			c_ph   = PH_COUNT;
			c_col  = '0;
			c_line = {1'b0, h_eff} - LINE_W'(1);
			c_dlo  = h_eff;
			c_dhi  = '0;
		end else begin
			c_ph   = phase_q;
			c_col  = column_q;
			c_line = line_q;
			c_dlo  = dlo_q;
			c_dhi  = dhi_q;
		end
	end

	// Range checks against the current column and row
	assign sum_count = {1'b0, c_col} + LINE_W'(count_q);
	assign sum_byte  = {1'b0, c_col} + LINE_W'(data_byte);
	assign sum_dx    = {1'b0, c_col} + LINE_W'(dx_q);
	assign bad_count = sum_count > {1'b0, w_eff};
	assign bad_byte  = sum_byte  > {1'b0, w_eff};
	assign bad_dx    = sum_dx    > {1'b0, w_eff};
	assign line_neg  = c_line[LINE_W-1];
	assign bad_dy    = $signed({{(LINE_W-BYTE_W){1'b0}}, data_byte}) > $signed(c_line);
	assign lit_dec   = lit_q - BYTE_W'(1);

	// Dirty span including the current row
	assign mark_lo = ({1'b0, c_line[POS_W-1:0]} < c_dlo) ? {1'b0, c_line[POS_W-1:0]} : c_dlo;
	assign mark_hi = (({1'b0, c_line[POS_W-1:0]} + DIM_W'(1)) > c_dhi)
		? ({1'b0, c_line[POS_W-1:0]} + DIM_W'(1)) : c_dhi;

	// Decode one byte
	always_comb begin
		n_ph    = c_ph;
		n_col   = c_col;
		n_line  = c_line;
		n_dlo   = c_dlo;
		n_dhi   = c_dhi;
		n_count = count_q;
		n_lit   = lit_q;
		n_pad   = pad_q;
		n_dx    = dx_q;
		paint   = 1'b0;
		finish  = 1'b0;
		err     = 1'b0;

		paint_res             = '0;
		paint_res.col         = c_col[POS_W-1:0];
		paint_res.row         = c_line[POS_W-1:0];
		paint_res.pixel_index = data_byte;

		unique case (c_ph)
			PH_COUNT: begin
				if (last_byte) begin
					finish = 1'b1;
				end else begin
					n_count = data_byte;
					n_ph    = PH_VALUE;
				end
			end
			PH_VALUE: begin
				n_ph = PH_COUNT;
				if (count_q != '0) begin
					if (line_neg || bad_count) begin
						err = 1'b1;
					end else begin
						paint                = 1'b1;
						paint_res.kind       = KIND_RUN;
						paint_res.run_length = count_q;
						n_col                = sum_count[DIM_W-1:0];
						n_dlo                = mark_lo;
						n_dhi                = mark_hi;
						finish               = last_byte;
					end
				end else if (data_byte == 8'd0) begin
					// end of line
					n_col = '0;
					if (!line_neg) begin
						n_line = c_line - LINE_W'(1);
					end
					finish = last_byte;
				end else if (data_byte == 8'd1) begin
					// end of bitmap
					finish = 1'b1;
					n_ph   = PH_DISCARD;
				end else if (data_byte == 8'd2) begin
					// delta escape
					if (last_byte) begin
						finish = 1'b1;
					end else begin
						n_ph = PH_DX;
					end
				end else begin
					// absolute copy
					if (line_neg || bad_byte || last_byte) begin
						err = 1'b1;
					end else begin
						n_lit = data_byte;
						n_pad = data_byte[0];
						n_dlo = mark_lo;
						n_dhi = mark_hi;
						n_ph  = PH_LITERAL;
					end
				end
			end
			PH_DX: begin
				if (last_byte) begin
					finish = 1'b1;
				end else begin
					n_dx = data_byte;
					n_ph = PH_DY;
				end
			end
			PH_DY: begin
				if (bad_dx || bad_dy) begin
					err = 1'b1;
				end else begin
					n_col  = sum_dx[DIM_W-1:0];
					n_line = c_line - LINE_W'(data_byte);
					n_ph   = PH_COUNT;
					finish = last_byte;
				end
			end
			PH_LITERAL: begin
				paint                = 1'b1;
				paint_res.kind       = KIND_PIXEL;
				paint_res.run_length = BYTE_W'(1);
				n_col                = c_col + DIM_W'(1);
				n_lit                = lit_dec;
				if (lit_dec == '0) begin
					n_ph = pad_q ? PH_PAD : PH_COUNT;
				end
				if (last_byte) begin
					if (lit_dec == '0) begin
						finish = 1'b1;
					end else begin
						err = 1'b1;
					end
				end
			end
			PH_PAD: begin
				n_ph   = PH_COUNT;
				finish = last_byte;
			end
			default: begin
				// discard until end of packet
			end
		endcase

		if (err) begin
			n_ph = PH_DISCARD;
		end
		if (last_byte) begin
			n_ph = PH_START;
		end
	end

	// Build the finish or error result
	always_comb begin
		end_res = '0;
		if (err) begin
			end_res.kind = KIND_ERROR;
		end else begin
			end_res.kind            = KIND_DONE;
			end_res.dirty_first_row = n_dlo;
			end_res.dirty_end_row   = n_dhi;
		end
		end_res.last = 1'b1;
	end

	// Order the results of this byte
	always_comb begin
		push = '0;
		if (paint) begin
			push.res0      = paint_res;
			push.res0.last = !(err || finish);
			push.res1      = end_res;
			push.cnt       = (err || finish) ? 2'd2 : 2'd1;
		end else if (err || finish) begin
			push.res0 = end_res;
			push.cnt  = 2'd1;
		end
		if (!fire) begin
			push.cnt = 2'd0;
		end
	end

	// Hold control state
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			phase_q  <= PH_START;
			column_q <= '0;
			line_q   <= LINE_W'(239);
			dlo_q    <= DIM_W'(240);
			dhi_q    <= '0;
			count_q  <= '0;
			lit_q    <= '0;
			pad_q    <= 1'b0;
			dx_q     <= '0;
		end else if (fire) begin
			phase_q  <= n_ph;
			column_q <= n_col;
			line_q   <= n_line;
			dlo_q    <= n_dlo;
			dhi_q    <= n_dhi;
			count_q  <= n_count;
			lit_q    <= n_lit;
			pad_q    <= n_pad;
			dx_q     <= n_dx;
		end
	end

endmodule

@@ rtl/core/rle8_res_fifo.sv @@
// ----------------------------------------------------------------------------
// RLE8 result queue
// Four-entry result queue; takes up to two results a cycle, gives one.
// ----------------------------------------------------------------------------
module rle8_res_fifo
	import rle8_pkg::*;
(
	input  logic    clk,
	input  logic    arst_n,
	input  push_t   push,
	output logic    space,
	output logic    out_valid,
	input  logic    out_ready,
	output result_t out_res
);

	localparam int DEPTH = 4;
	localparam int PTR_W = $clog2(DEPTH);

	result_t            entry_q [DEPTH];
	logic [PTR_W-1:0]   wr_q, rd_q, wr_next;
	logic [PTR_W:0]     cnt_q;
	logic               pop;

	assign out_valid = cnt_q != '0;
	assign out_res   = entry_q[rd_q];
	assign pop       = out_valid && out_ready;
	assign space     = cnt_q <= (PTR_W+1)'(DEPTH - 2);
	assign wr_next   = wr_q + PTR_W'(1);

	// Store pushed results
	always_ff @(posedge clk) begin
		if (push.cnt != 2'd0) begin
			entry_q[wr_q] <= push.res0;
		end
		if (push.cnt == 2'd2) begin
			entry_q[wr_next] <= push.res1;
		end
	end

	// Advance pointers and fill count
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_q  <= '0;
			rd_q  <= '0;
			cnt_q <= '0;
		end else begin
			wr_q  <= wr_q + PTR_W'(push.cnt);
			if (pop) begin
				rd_q <= rd_q + PTR_W'(1);
			end
			cnt_q <= cnt_q + (PTR_W+1)'(push.cnt) - (PTR_W+1)'(pop);
		end
	end

endmodule

@@ rtl/core/rle8_bitmap_decoder_top.sv @@
// ----------------------------------------------------------------------------
// RLE8 bitmap decoder top level
// Decodes BI_RLE8 packet bytes into run-fill, pixel, finish and error results.
// ----------------------------------------------------------------------------
//  Channel  Dir  Payload                                         Transfer
//  in_ch    in   data_byte, last_byte                            valid & ready
//  out_ch   out  kind, col, row, run_length, pixel_index,        valid & ready
//                dirty_first_row, dirty_end_row, last
//  cfg      in   reg_index (0 width, 1 height), write_data       valid & ready
//
//  One byte per cycle while in_ch.ready is high; the results of a byte are
//  registered in a four-entry result queue before out_ch, which sends them
//  singly; in_ch.ready drops only when the queue has under two free slots.
//  Reset: width 320, height 240, decoder waits for the first packet byte.
//  The register port is always ready.
// ----------------------------------------------------------------------------
module rle8_bitmap_decoder_top
	import rle8_pkg::*;
(
	input  logic      clk,
	input  logic      arst_n,
	rle8_in_if.sink   in_ch,
	rle8_out_if.source out_ch,
	rle8_cfg_if.sink  cfg
);

	logic [DIM_W-1:0] frame_width_q, frame_height_q;
	logic             space, fire;
	push_t            push;
	result_t          res;

	// Write configuration registers
	assign cfg.ready = 1'b1;
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			frame_width_q  <= DIM_W'(320);
			frame_height_q <= DIM_W'(240);
		end else if (cfg.valid) begin
			if (cfg.reg_index == REG_FRAME_WIDTH) begin
				frame_width_q <= cfg.write_data;
			end
			if (cfg.reg_index == REG_FRAME_HEIGHT) begin
				frame_height_q <= cfg.write_data;
			end
		end
	end

	assign in_ch.ready = space;
	assign fire        = in_ch.valid && space;

	rle8_dec_core u_core (
		.clk          (clk),
		.arst_n       (arst_n),
		.fire         (fire),
		.data_byte    (in_ch.data_byte),
		.last_byte    (in_ch.last_byte),
		.frame_width  (frame_width_q),
		.frame_height (frame_height_q),
		.push         (push)
	);

	rle8_res_fifo u_fifo (
		.clk       (clk),
		.arst_n    (arst_n),
		.push      (push),
		.space     (space),
		.out_valid (out_ch.valid),
		.out_ready (out_ch.ready),
		.out_res   (res)
	);

	// Drive result fields
	assign out_ch.kind            = res.kind;
	assign out_ch.col             = res.col;
	assign out_ch.row             = res.row;
	assign out_ch.run_length      = res.run_length;
	assign out_ch.pixel_index     = res.pixel_index;
	assign out_ch.dirty_first_row = res.dirty_first_row;
	assign out_ch.dirty_end_row   = res.dirty_end_row;
	assign out_ch.last            = res.last;

endmodule

@@ bench/tb_rle8_bitmap_decoder_top.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// RLE8 bitmap decoder testbench
// Feeds BI_RLE8 packets byte by byte and keeps its own decoder state to work
// out the run-fill, pixel, finish and error results of every byte, then checks
// each result transfer in order. Directed packets cover the escapes, the pad
// byte, truncation and the error paths; random packets follow under several
// frame sizes and handshake idling patterns, including one long output stall.
// ----------------------------------------------------------------------------
module tb_rle8_bitmap_decoder_top;
	import rle8_pkg::*;

	localparam int ESC_MARK      = 0;      // count byte that starts an escape
	localparam int ESC_EOL       = 0;
	localparam int ESC_EOB       = 1;
	localparam int ESC_DELTA     = 2;
	localparam int SETTLE_CYCLES = 8;
	localparam int HOLD_CYCLES   = 400;
	localparam int STALL_LIMIT   = 3000;
	localparam int PHASE_BYTES   = 160;

	typedef struct packed {
		logic [7:0] value;
		logic       last_flag;
	} pkt_byte_t;

	logic clk = 1'b0;
	logic arst_n = 1'b0;

	rle8_in_if  in_ch();
	rle8_out_if out_ch();
	rle8_cfg_if cfg();

	rle8_bitmap_decoder_top uut (
		.clk    (clk),
		.arst_n (arst_n),
		.in_ch  (in_ch),
		.out_ch (out_ch),
		.cfg    (cfg)
	);

	// Stimulus and expectation stores
	pkt_byte_t byte_q[$];
	pkt_byte_t build_q[$];
	result_t   expected_results[$];
	pkt_byte_t drv_item;
	int        bytes_queued = 0;
	int        bytes_taken = 0;
	int        mismatches = 0;
	int        src_idle_pct = 0;
	int        snk_stall_pct = 0;
	int        stalled_cycles = 0;
	logic      hold_req = 1'b0;
	logic      hold_ack;
	int        hold_left;

	// Decoder state as the bench sees it
	logic [12:0] width_reg;
	logic [12:0] height_reg;
	phase_t      dec_phase;
	int          col_pos;
	int          line_pos;
	int          held_count;
	int          lit_left;
	bit          pad_due;
	int          held_dx;
	int          dirty_lo;
	int          dirty_hi;

	always begin
		#5 clk = 1'b1;
		#5 clk = 1'b0;
	end

	function automatic int cap(int a, int b);
		return (a < b) ? a : b;
	endfunction

	function automatic result_t make_result(kind_t k, int c, int r, int len, int pix,
		int dlo, int dhi);
		result_t x;
		x.kind            = k;
		x.col             = 12'(c);
		x.row             = 12'(r);
		x.run_length      = 8'(len);
		x.pixel_index     = 8'(pix);
		x.dirty_first_row = 13'(dlo);
		x.dirty_end_row   = 13'(dhi);
		x.last            = 1'b0;
		return x;
	endfunction

	function automatic string result_str(result_t r);
		return $sformatf("kind=%0d col=%0d row=%0d len=%0d pix=%0d dirty=%0d..%0d last=%0d",
			r.kind, r.col, r.row, r.run_length, r.pixel_index, r.dirty_first_row,
			r.dirty_end_row, r.last);
	endfunction

	function automatic void mark_rows();
		if (line_pos < dirty_lo)
			dirty_lo = line_pos;
		if (line_pos + 1 > dirty_hi)
			dirty_hi = line_pos + 1;
	endfunction

	// Advance the decoder by one packet byte and queue the results it causes
	function automatic void decode_byte(logic [7:0] data, logic lastb);
		int      b, w, h, n;
		bit      finish, err;
		result_t res [2];
		b = data;
		w = (width_reg > MAX_WIDTH) ? MAX_WIDTH : int'(width_reg);
		h = (height_reg > MAX_HEIGHT) ? MAX_HEIGHT : int'(height_reg);
		n = 0;
		finish = 1'b0;
		err = 1'b0;

		// Reload position and dirty span on the first byte of a packet
		if (dec_phase == PH_START) begin
			col_pos = 0;
			line_pos = h - 1;
			dirty_lo = h;
			dirty_hi = 0;
			dec_phase = PH_COUNT;
		end

		case (dec_phase)
			PH_COUNT: begin
				if (lastb)
					finish = 1'b1;
				else begin
					held_count = b;
					dec_phase = PH_VALUE;
				end
			end
			PH_VALUE: begin
				dec_phase = PH_COUNT;
				if (held_count != 0) begin
					if (line_pos < 0 || held_count > w - col_pos)
						err = 1'b1;
					else begin
						res[n] = make_result(KIND_RUN, col_pos, line_pos, held_count, b, 0, 0);
						n++;
						col_pos += held_count;
						mark_rows();
						if (lastb)
							finish = 1'b1;
					end
				end else if (b == ESC_EOL) begin
					col_pos = 0;
					if (line_pos > -1)
						line_pos--;
					if (lastb)
						finish = 1'b1;
				end else if (b == ESC_EOB) begin
					finish = 1'b1;
					dec_phase = PH_DISCARD;
				end else if (b == ESC_DELTA) begin
					if (lastb)
						finish = 1'b1;
					else
						dec_phase = PH_DX;
				end else begin
					if (line_pos < 0 || b > w - col_pos || lastb)
						err = 1'b1;
					else begin
						lit_left = b;
						pad_due = b[0];
						mark_rows();
						dec_phase = PH_LITERAL;
					end
				end
			end
			PH_DX: begin
				if (lastb)
					finish = 1'b1;
				else begin
					held_dx = b;
					dec_phase = PH_DY;
				end
			end
			PH_DY: begin
				if (held_dx > w - col_pos || b > line_pos)
					err = 1'b1;
				else begin
					col_pos += held_dx;
					line_pos -= b;
					dec_phase = PH_COUNT;
					if (lastb)
						finish = 1'b1;
				end
			end
			PH_LITERAL: begin
				res[n] = make_result(KIND_PIXEL, col_pos, line_pos, 1, b, 0, 0);
				n++;
				col_pos++;
				lit_left = (lit_left - 1) & 8'hFF;
				if (lit_left == 0)
					dec_phase = pad_due ? PH_PAD : PH_COUNT;
				if (lastb) begin
					if (lit_left == 0)
						finish = 1'b1;
					else
						err = 1'b1;
				end
			end
			PH_PAD: begin
				dec_phase = PH_COUNT;
				if (lastb)
					finish = 1'b1;
			end
			default: begin
			end
		endcase

		if (err) begin
			res[n] = make_result(KIND_ERROR, 0, 0, 0, 0, 0, 0);
			n++;
			dec_phase = PH_DISCARD;
		end else if (finish) begin
			res[n] = make_result(KIND_DONE, 0, 0, 0, 0, dirty_lo, dirty_hi);
			n++;
		end
		if (lastb)
			dec_phase = PH_START;
		if (n > 0)
			res[n-1].last = 1'b1;
		for (int i = 0; i < n; i++)
			expected_results.push_back(res[i]);
	endfunction

	// Packet building
	function automatic void put_byte(int b);
		pkt_byte_t it;
		it.value = 8'(b);
		it.last_flag = 1'b0;
		build_q.push_back(it);
	endfunction

	function automatic void end_packet();
		pkt_byte_t it;
		it = build_q.pop_back();
		it.last_flag = 1'b1;
		build_q.push_back(it);
		foreach (build_q[i])
			byte_q.push_back(build_q[i]);
		bytes_queued += build_q.size();
		build_q.delete();
	endfunction

	// Mostly well-formed packet for a w x h frame, with some noise and odd endings
	function automatic void build_packet(int w, int h);
		int gc, gl, room, sel, n, dx, dy, cut, ending;
		gc = 0;
		gl = h - 1;
		repeat ($urandom_range(1, 8)) begin
			room = w - gc;
			sel = $urandom_range(0, 99);
			if (sel < 6) begin
				put_byte($urandom_range(0, 255));
				put_byte($urandom_range(0, 255));
			end else if (gl < 0 || room < 1 || sel < 22) begin
				put_byte(ESC_MARK);
				put_byte(ESC_EOL);
				gc = 0;
				if (gl >= 0)
					gl--;
			end else if (sel < 55) begin
				if ($urandom_range(0, 24) == 0)
					n = $urandom_range(1, 255);
				else
					n = $urandom_range(1, cap(room, 255));
				put_byte(n);
				put_byte($urandom_range(0, 255));
				gc += n;
			end else if (sel < 82 && room >= 3) begin
				if ($urandom_range(0, 29) == 0)
					n = $urandom_range(3, cap(room, 255));
				else
					n = $urandom_range(3, cap(room, 12));
				put_byte(ESC_MARK);
				put_byte(n);
				repeat (n)
					put_byte($urandom_range(0, 255));
				if (n % 2)
					put_byte($urandom_range(0, 255));
				gc += n;
			end else begin
				if (gl < 0 || $urandom_range(0, 9) == 0) begin
					dx = $urandom_range(0, 255);
					dy = $urandom_range(0, 255);
				end else begin
					dx = $urandom_range(0, cap(room, 255));
					dy = $urandom_range(0, cap(gl, 255));
				end
				put_byte(ESC_MARK);
				put_byte(ESC_DELTA);
				put_byte(dx);
				put_byte(dy);
				gc += dx;
				gl -= dy;
			end
		end

		// Close with end of bitmap, a lone count byte, or cut the packet short
		ending = $urandom_range(0, 9);
		if (ending < 5) begin
			put_byte(ESC_MARK);
			put_byte(ESC_EOB);
			if ($urandom_range(0, 2) == 0) begin
				put_byte($urandom_range(0, 255));
				put_byte($urandom_range(0, 255));
			end
		end else if (ending < 7)
			put_byte($urandom_range(0, 255));
		else begin
			cut = $urandom_range(1, build_q.size());
			while (build_q.size() > cut)
				void'(build_q.pop_back());
		end
		end_packet();
	endfunction

	task automatic write_reg(logic [1:0] idx, int val);
		@(posedge clk);
		cfg.valid <= 1'b1;
		cfg.reg_index <= idx;
		cfg.write_data <= 13'(val);
		do
			@(posedge clk);
		while (!cfg.ready);
		cfg.valid <= 1'b0;
	endtask

	// Hold until every queued byte is taken and every result has come back
	task automatic wait_idle();
		while (bytes_taken != bytes_queued || expected_results.size() != 0)
			@(posedge clk);
		repeat (SETTLE_CYCLES)
			@(posedge clk);
	endtask

	// Byte driver: offer the next queued byte, idling at random
	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			in_ch.valid <= 1'b0;
			in_ch.data_byte <= '0;
			in_ch.last_byte <= 1'b0;
		end else if (!in_ch.valid || in_ch.ready) begin
			if (byte_q.size() != 0 && $urandom_range(0, 99) >= src_idle_pct) begin
				drv_item = byte_q.pop_front();
				in_ch.valid <= 1'b1;
				in_ch.data_byte <= drv_item.value;
				in_ch.last_byte <= drv_item.last_flag;
			end else
				in_ch.valid <= 1'b0;
		end
	end

	// Long output hold-off, started by a toggle of hold_req
	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			hold_left <= 0;
			hold_ack <= 1'b0;
		end else if (hold_req != hold_ack) begin
			hold_left <= HOLD_CYCLES;
			hold_ack <= hold_req;
		end else if (hold_left != 0)
			hold_left <= hold_left - 1;
	end

	// Result receiver: stall at random or during a hold-off
	always @(posedge clk or negedge arst_n) begin
		if (!arst_n)
			out_ch.ready <= 1'b0;
		else
			out_ch.ready <= (hold_left == 0) && ($urandom_range(0, 99) >= snk_stall_pct);
	end

	// Monitor: track register writes, predict on each byte transfer, check results
	always @(posedge clk or negedge arst_n) begin
		result_t got, want;
		if (!arst_n) begin
			width_reg = 13'd320;
			height_reg = 13'd240;
			dec_phase = PH_START;
			col_pos = 0;
			line_pos = 239;
			held_count = 0;
			lit_left = 0;
			pad_due = 1'b0;
			held_dx = 0;
			dirty_lo = 240;
			dirty_hi = 0;
		end else begin
			if (cfg.valid && cfg.ready) begin
				if (cfg.reg_index == REG_FRAME_WIDTH)
					width_reg = cfg.write_data;
				else if (cfg.reg_index == REG_FRAME_HEIGHT)
					height_reg = cfg.write_data;
			end
			if (in_ch.valid && in_ch.ready) begin
				decode_byte(in_ch.data_byte, in_ch.last_byte);
				bytes_taken++;
			end
			if (out_ch.valid && out_ch.ready) begin
				got.kind            = kind_t'(out_ch.kind);
				got.col             = out_ch.col;
				got.row             = out_ch.row;
				got.run_length      = out_ch.run_length;
				got.pixel_index     = out_ch.pixel_index;
				got.dirty_first_row = out_ch.dirty_first_row;
				got.dirty_end_row   = out_ch.dirty_end_row;
				got.last            = out_ch.last;
				if (expected_results.size() == 0) begin
					mismatches++;
					if (mismatches <= 10)
						$display("unexpected result: %s", result_str(got));
				end else begin
					want = expected_results.pop_front();
					if (got !== want) begin
						mismatches++;
						if (mismatches <= 10)
							$display("mismatch: expected %s, got %s", result_str(want),
								result_str(got));
					end
				end
			end
		end
	end

	// Watchdog on cycles without any transfer
	always @(posedge clk) begin
		if (arst_n) begin
			if ((in_ch.valid && in_ch.ready) || (out_ch.valid && out_ch.ready) ||
				(cfg.valid && cfg.ready))
				stalled_cycles <= 0;
			else if (stalled_cycles >= STALL_LIMIT) begin
				$display("RESULT: ERROR");
				$finish;
			end else
				stalled_cycles <= stalled_cycles + 1;
		end
	end

	initial begin
		int w_val, h_val, mark;
		cfg.valid <= 1'b0;
		cfg.reg_index <= '0;
		cfg.write_data <= '0;
		repeat (6)
			@(posedge clk);
		arst_n <= 1'b1;

		// Reset size: run, odd copy with pad, end of line, delta, run past the width
		put_byte(5);    put_byte(8'hAA);
		put_byte(ESC_MARK); put_byte(3);
		put_byte(8'h01); put_byte(8'hFE); put_byte(8'h80); put_byte(8'h00);
		put_byte(ESC_MARK); put_byte(ESC_EOL);
		put_byte(ESC_MARK); put_byte(ESC_DELTA); put_byte(100); put_byte(1);
		put_byte(255);  put_byte(7);
		end_packet();
		// End of bitmap, then a trailing byte that is dropped
		put_byte(ESC_MARK); put_byte(ESC_EOB); put_byte(8'h77);
		end_packet();
		// Copy cut short by the end of the packet
		put_byte(ESC_MARK); put_byte(4); put_byte(8'h11); put_byte(8'h22);
		end_packet();
		wait_idle();

		// Zero width: any run fails
		write_reg(REG_FRAME_WIDTH, 0);
		put_byte(3); put_byte(9);
		end_packet();
		wait_idle();

		// Zero height: start above the top, end of line saturates, paint fails
		write_reg(REG_FRAME_WIDTH, 320);
		write_reg(REG_FRAME_HEIGHT, 0);
		put_byte(ESC_MARK); put_byte(ESC_EOL); put_byte(1); put_byte(9);
		end_packet();
		wait_idle();

		// Random packets under several frame sizes and idling patterns
		for (int p = 0; p < 8; p++) begin
			case (p)
				0: begin w_val = 24;   h_val = 12;   end
				1: begin w_val = 1;    h_val = 1;    end
				2: begin w_val = 4096; h_val = 4096; end
				3: begin w_val = 40;   h_val = 3;    end
				4: begin w_val = 8191; h_val = 6;    end
				5: begin w_val = 3;    h_val = 4096; end
				6: begin w_val = 64;   h_val = 2;    end
				default: begin
					w_val = $urandom_range(1, 4096);
					h_val = $urandom_range(1, 4096);
				end
			endcase
			write_reg(REG_FRAME_WIDTH, w_val);
			write_reg(REG_FRAME_HEIGHT, h_val);
			case (p % 4)
				0: begin src_idle_pct = 0;  snk_stall_pct = 0;  end
				1: begin src_idle_pct = 82; snk_stall_pct = 0;  end
				2: begin src_idle_pct = 0;  snk_stall_pct = 82; end
				default: begin src_idle_pct = 13; snk_stall_pct = 13; end
			endcase
			mark = bytes_queued;
			while (bytes_queued - mark < PHASE_BYTES)
				build_packet(cap(w_val, MAX_WIDTH), cap(h_val, MAX_HEIGHT));
			// Stall the output for a long stretch while bytes keep coming
			if (p == 0) begin
				while (bytes_taken < mark + 20)
					@(posedge clk);
				hold_req <= ~hold_req;
			end
			wait_idle();
		end

		mismatches += expected_results.size();
		if (mismatches == 0)
			$display("RESULT: OK");
		else
			$display("RESULT: ERROR");
		$finish;
	end

endmodule
